// File: hdl/strp_pkg.sv
// Shared types and constants for the scroll tile refresh planner.
// No dependencies; imported by every module of the block.
package strp_pkg;

  // Map and ring geometry
  localparam int MAP_COLS   = 60;
  localparam int MAP_ROWS   = 40;
  localparam int RING_TILES = 32;
  localparam int VIEW_ROWS  = 22;
  localparam int AHEAD_COLS = 30;
  localparam int AHEAD_ROWS = 20;
  localparam int STRIP_ROWS = VIEW_ROWS - 1;
  localparam int STRIP_COLS = RING_TILES - 1;

  // Reset value of the x clamp register
  localparam logic [11:0] MAX_X_RESET = 12'd240;

  // Requests per frame and queue sizing
  localparam int MAX_REQ     = 5;
  localparam int REQ_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Remainder width for the map modulo units (map up to 256 tiles)
  localparam int MOD_W = 8;

  // Port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // One copy request, packed so that src_col sits in the lowest bits
  typedef struct packed {
    logic [4:0] row_count;
    logic [5:0] width_tiles;
    logic [4:0] dst_row;
    logic [4:0] dst_col;
    logic [5:0] src_row;
    logic [5:0] src_col;
  } req_t;

  // All requests of one frame, in emission order from index 0
  typedef struct packed {
    req_t [MAX_REQ-1:0]   req;
    logic [REQ_IDX_W-1:0] count;
  } plan_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/scroll_tile_refresh_planner.sv
// Top level of the scroll tile refresh planner: front end, plan queue, back end.
// Depends on strp_pkg, strp_front, strp_queue and strp_back.
//
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+---------------------------------------------
// in_     | in  | in_tvalid / in_tready  | tdata: camera_x, camera_y; tuser: full_refresh
// out_    | out | out_tvalid / out_tready| tdata: copy request; tlast: last of frame
// cfg_    | in  | cfg_wen                | cfg_wdata: max_camera_x
//
// A frame passes two front stages (clamp, map remainders) and then its 1 to 5
// requests are queued as one plan, while a frame with none skips the queue; the back
// end emits one request per cycle while the output is not stalled. Sustained rate is
// set by the single output register; an accepted input passes the stage 1 and stage 2
// registers, the queue and the output register before its first request is offered.
// Reset (rst_n low, synchronous) clears the kept tile position, queue and
// output valid, and loads max_camera_x with 240.
// A stalled output fills the queue (4 plans) and then the front stages.
module scroll_tile_refresh_planner import strp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [11:0]            cfg_wdata,    // max_camera_x
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // camera_x [15:0], camera_y [31:16]
  input  logic                   in_tuser,     // full_refresh
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // src_col [5:0], src_row [11:6], dst_col [16:12], dst_row [21:17],
  // width_tiles [27:22], row_count [32:28], zero [39:33]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast     // last
);

  q_stat_t q_stat;
  logic    push, pop;
  plan_t   push_plan, head;

  strp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_plan (push_plan)
  );

  strp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  strp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/strp_front.sv
// Front end: clamps the camera position, reduces it to tiles, compares with the
// kept tile position and builds the frame's request list. Depends on strp_pkg.
module strp_front import strp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [11:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  q_stat_t               q_stat,
  output logic                  push,
  output plan_t                 push_plan
);

  localparam int COL_STEPS = 10 - $clog2(MAP_COLS) + 1;
  localparam int ROW_STEPS = 13 - $clog2(MAP_ROWS) + 1;

  // Remainder by MAP_COLS of a 10-bit value, restoring subtract steps
  function automatic logic [MOD_W-1:0] mod_cols(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    for (int i = COL_STEPS - 1; i >= 0; i--) begin
      if (r >= 10'(MAP_COLS << i)) r = r - 10'(MAP_COLS << i);
    end
    return r[MOD_W-1:0];
  endfunction

  // Remainder by MAP_ROWS of a 13-bit value
  function automatic logic [MOD_W-1:0] mod_rows(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    for (int i = ROW_STEPS - 1; i >= 0; i--) begin
      if (r >= 13'(MAP_ROWS << i)) r = r - 13'(MAP_ROWS << i);
    end
    return r[MOD_W-1:0];
  endfunction

  // Clamp register
  logic [11:0] max_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= MAX_X_RESET;
    end else if (cfg_wen) begin
      max_x_r <= cfg_wdata;
    end
  end

  // Stage 1: clamp and tile conversion
  logic        s1_v_r, s1_v_nxt;
  logic [8:0]  s1_cx_r;
  logic [11:0] s1_cy_r;
  logic        s1_ref_r;
  logic [15:0] raw_x, raw_y;
  logic [11:0] x_clamped;
  logic        in_acc, s1_ready, s2_ready, s2_take;

  assign raw_x  = in_tdata[15:0];
  assign raw_y  = in_tdata[31:16];
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    if (raw_x[15]) begin
      x_clamped = '0;
    end else if (raw_x[14:0] > {3'b000, max_x_r}) begin
      x_clamped = max_x_r;
    end else begin
      x_clamped = raw_x[11:0];
    end
  end

  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign s1_v_nxt  = (s1_v_r && !s2_ready) || in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cx_r  <= x_clamped[11:3];
      s1_cy_r  <= raw_y[15] ? 12'd0 : raw_y[14:3];
      s1_ref_r <= in_tuser;
    end
  end

  // Stage 2: map remainders of the tile position and its derived columns/rows
  logic             s2_v_r, s2_v_nxt;
  logic [8:0]       s2_cx_r;
  logic [11:0]      s2_cy_r;
  logic             s2_ref_r;
  logic [MOD_W-1:0] cx_m_r, cy_m_r, cxa_m_r, cxw_m_r, cyd_m_r;
  logic             s1_move;

  assign s1_move  = s1_v_r && s2_ready;
  assign s2_v_nxt = (s2_v_r && !s2_take) || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_cx_r  <= s1_cx_r;
      s2_cy_r  <= s1_cy_r;
      s2_ref_r <= s1_ref_r;
      cx_m_r   <= mod_cols({1'b0, s1_cx_r});
      cy_m_r   <= mod_rows({1'b0, s1_cy_r});
      cxa_m_r  <= mod_cols({1'b0, s1_cx_r} + 10'(AHEAD_COLS));
      // next ring-aligned column past cx
      cxw_m_r  <= mod_cols({1'b0, s1_cx_r[8:5], 5'b11111} + 10'd1);
      cyd_m_r  <= mod_rows({1'b0, s1_cy_r} + 13'(AHEAD_ROWS));
    end
  end

  // Kept tile position
  logic [11:0] prev_col_r, prev_col_nxt;
  logic [11:0] prev_row_r, prev_row_nxt;

  // Classification and request list
  logic [11:0]          cxe, col_diff, row_diff;
  logic [4:0]           d;
  logic                 d_nz, right, down, col_chg, row_chg, col_jump, row_jump;
  logic [8:0]           strip_sum;
  req_t                 full0, full1, cs, r0, r1;
  req_t [MAX_REQ-1:0]   lst;
  logic [REQ_IDX_W-1:0] n;

  always_comb begin
    cxe  = {3'b000, s2_cx_r};
    d    = s2_cx_r[4:0];
    d_nz = (d != 5'd0);

    right    = cxe > prev_col_r;
    down     = s2_cy_r > prev_row_r;
    col_chg  = cxe != prev_col_r;
    row_chg  = s2_cy_r != prev_row_r;
    col_diff = right ? cxe - prev_col_r : prev_col_r - cxe;
    row_diff = down ? s2_cy_r - prev_row_r : prev_row_r - s2_cy_r;
    col_jump = col_diff > 12'd1;
    row_jump = row_diff > 12'd1;

    // full view copy, split at the ring wrap
    full0.src_col     = cx_m_r[5:0];
    full0.src_row     = cy_m_r[5:0];
    full0.dst_col     = d;
    full0.dst_row     = s2_cy_r[4:0];
    full0.width_tiles = 6'(RING_TILES) - {1'b0, d};
    full0.row_count   = 5'(VIEW_ROWS);
    full1.src_col     = cxw_m_r[5:0];
    full1.src_row     = cy_m_r[5:0];
    full1.dst_col     = '0;
    full1.dst_row     = s2_cy_r[4:0];
    full1.width_tiles = {1'b0, d};
    full1.row_count   = 5'(VIEW_ROWS);

    // column strip, clipped at the map's bottom edge
    strip_sum      = {1'b0, cy_m_r} + 9'(STRIP_ROWS);
    cs.src_col     = right ? cxa_m_r[5:0] : s2_cx_r[5:0];
    cs.src_row     = cy_m_r[5:0];
    cs.dst_col     = right ? d + 5'(AHEAD_COLS) : d;
    cs.dst_row     = s2_cy_r[4:0];
    cs.width_tiles = 6'd1;
    cs.row_count   = (strip_sum < 9'(MAP_ROWS)) ? 5'(STRIP_ROWS)
                                                : 5'(9'(MAP_ROWS) - {1'b0, cy_m_r});

    // row strip, one piece when ring-aligned, else two
    r0.src_col     = cx_m_r[5:0];
    r0.src_row     = down ? cyd_m_r[5:0] : s2_cy_r[5:0];
    r0.dst_col     = d;
    r0.dst_row     = down ? s2_cy_r[4:0] + 5'(AHEAD_ROWS) : s2_cy_r[4:0];
    r0.width_tiles = d_nz ? 6'(RING_TILES) - {1'b0, d} : 6'(STRIP_COLS);
    r0.row_count   = 5'd1;
    r1.src_col     = cxw_m_r[5:0];
    r1.src_row     = r0.src_row;
    r1.dst_col     = '0;
    r1.dst_row     = r0.dst_row;
    r1.width_tiles = {1'b0, d} - 6'd1;
    r1.row_count   = 5'd1;

    lst          = '0;
    n            = '0;
    prev_col_nxt = prev_col_r;
    prev_row_nxt = prev_row_r;

    if (s2_ref_r) begin
      lst[n] = full0;
      n = n + 3'd1;
      if (d_nz) begin
        lst[n] = full1;
        n = n + 3'd1;
      end
    end

    if (col_chg && col_jump) begin
      lst[n] = full0;
      n = n + 3'd1;
      if (d_nz) begin
        lst[n] = full1;
        n = n + 3'd1;
      end
      prev_col_nxt = cxe;
      prev_row_nxt = s2_cy_r;
    end else begin
      if (col_chg) begin
        lst[n] = cs;
        n = n + 3'd1;
        prev_col_nxt = cxe;
      end
      if (row_chg) begin
        if (row_jump) begin
          lst[n] = full0;
          n = n + 3'd1;
          if (d_nz) begin
            lst[n] = full1;
            n = n + 3'd1;
          end
          prev_col_nxt = cxe;
        end else begin
          lst[n] = r0;
          n = n + 3'd1;
          if (d_nz) begin
            lst[n] = r1;
            n = n + 3'd1;
          end
        end
        prev_row_nxt = s2_cy_r;
      end
    end
  end

  // A frame with no requests leaves without a queue slot
  assign s2_take         = s2_v_r && (!q_stat.full || (n == '0));
  assign s2_ready        = !s2_v_r || s2_take;
  assign push            = s2_v_r && (n != '0) && !q_stat.full;
  assign push_plan.req   = lst;
  assign push_plan.count = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_col_r <= '0;
      prev_row_r <= '0;
    end else if (s2_take) begin
      prev_col_r <= prev_col_nxt;
      prev_row_r <= prev_row_nxt;
    end
  end

endmodule

// File: hdl/strp_queue.sv
// Short plan queue between front and back ends.
// Depends on strp_pkg for plan_t, q_stat_t and the queue sizing.
module strp_queue import strp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  plan_t   push_plan,
  input  logic    pop,
  output plan_t   head,
  output q_stat_t q_stat
);

  plan_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

// File: hdl/strp_back.sv
// Back end: walks the head plan to the output register one request a cycle unless stalled.
// Depends on strp_pkg for plan_t, req_t and q_stat_t.
module strp_back import strp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  plan_t                  head,
  input  q_stat_t                q_stat,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic [REQ_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  req_t                 out_req_r;
  logic                 out_last_r;
  logic                 load, at_last;

  // Load a request while a plan is queued and the output register is free or draining
  always_comb begin
    load    = !q_stat.empty && (!out_valid_r || out_tready);
    at_last = (idx_r == head.count - 3'd1);
    pop     = load && at_last;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_last ? '0 : idx_r + 3'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_req_r  <= head.req[idx_r];
      out_last_r <= at_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_req_r);
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/strp_checker.sv
// Port-level checks for the scroll tile refresh planner, bound to the top level.
// Depends on strp_pkg and scroll_tile_refresh_planner.
module strp_checker import strp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Row count is never zero and never above the view height
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:28] != 5'd0) && (out_tdata[32:28] <= 5'(VIEW_ROWS)))
    else $error("row count out of range");

  // A full-ring-width piece always starts at ring column zero
  a_wide_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[27:22] == 6'(RING_TILES)) |-> (out_tdata[16:12] == 5'd0))
    else $error("full-width piece not ring aligned");

endmodule

bind scroll_tile_refresh_planner strp_checker u_strp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: bench/tb_scroll_tile_refresh_planner.sv
`timescale 1ns / 1ps
// Self-checking bench for scroll_tile_refresh_planner: camera frames in, copy requests out.
// Depends on strp_pkg and the RTL of the block; reads no files.
module tb_scroll_tile_refresh_planner;
  import strp_pkg::*;

  // One camera frame as presented on the input stream
  typedef struct {
    logic [15:0] cam_x;
    logic [15:0] cam_y;
    logic        refresh;
  } cam_frame_t;

  // One expected copy request and its end-of-frame marker
  typedef struct {
    req_t req;
    logic last;
  } copy_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [11:0]            cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Predictor state: x clamp and the tile position kept from the last update
  logic [11:0] x_limit;
  int unsigned kept_col;
  int unsigned kept_row;

  cam_frame_t  frames_to_send[$];
  copy_t       planned_copies[$];

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int          walk_x = 0;
  int          walk_y = 0;
  int          err_count = 0;
  int          frames_taken = 0;
  int          copies_checked = 0;

  scroll_tile_refresh_planner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one copy request; fields are cut to their port widths
  function automatic void queue_copy(int unsigned scol, int unsigned srow, int unsigned dcol,
                                     int unsigned drow, int unsigned wid, int unsigned rows);
    copy_t c;
    c.req.src_col     = 6'(scol);
    c.req.src_row     = 6'(srow);
    c.req.dst_col     = 5'(dcol % RING_TILES);
    c.req.dst_row     = 5'(drow % RING_TILES);
    c.req.width_tiles = 6'(wid);
    c.req.row_count   = 5'(rows);
    c.last            = 1'b0;
    planned_copies.push_back(c);
  endfunction

  // Whole view, split where the ring wraps
  function automatic void queue_full_view(int unsigned col, int unsigned row);
    int unsigned d;
    int unsigned w;
    d = col % RING_TILES;
    if (d != 0) begin
      w = RING_TILES - d;
      queue_copy(col % MAP_COLS, row % MAP_ROWS, col, row, w, VIEW_ROWS);
      queue_copy((col + w) % MAP_COLS, row % MAP_ROWS, col + w, row, RING_TILES - w, VIEW_ROWS);
    end else begin
      queue_copy(col % MAP_COLS, row % MAP_ROWS, col, row, RING_TILES, VIEW_ROWS);
    end
  endfunction

  // Work out the copy requests caused by one accepted frame
  function automatic void plan_frame(logic [15:0] cam_x, logic [15:0] cam_y, logic refresh);
    int unsigned x, y, tcol, trow;
    int unsigned scol, srow, dcol, drow, rows, d, w, n0;
    bit          done;
    n0   = planned_copies.size();
    done = 1'b0;
    x    = cam_x[15] ? 0 : ((cam_x > 16'(x_limit)) ? 32'(x_limit) : 32'(cam_x));
    y    = cam_y[15] ? 0 : 32'(cam_y);
    tcol = x >> 3;
    trow = y >> 3;

    if (refresh)
      queue_full_view(tcol, trow);

    // column: jump gives a full copy and ends the frame, a step gives one strip
    if (kept_col != tcol) begin
      if ((kept_col > tcol ? kept_col - tcol : tcol - kept_col) > 1) begin
        queue_full_view(tcol, trow);
        kept_col = tcol;
        kept_row = trow;
        done     = 1'b1;
      end else begin
        if (tcol > kept_col) begin
          dcol = tcol + AHEAD_COLS;
          scol = dcol % MAP_COLS;
        end else begin
          dcol = tcol;
          scol = tcol;
        end
        srow = trow % MAP_ROWS;
        rows = (srow + STRIP_ROWS < MAP_ROWS) ? STRIP_ROWS : MAP_ROWS - srow;
        queue_copy(scol, srow, dcol, trow, 1, rows);
        kept_col = tcol;
      end
    end

    // row: jump gives a full copy, a step gives a strip in one or two pieces
    if (!done && kept_row != trow) begin
      if ((kept_row > trow ? kept_row - trow : trow - kept_row) > 1) begin
        queue_full_view(tcol, trow);
        kept_col = tcol;
        kept_row = trow;
      end else begin
        if (trow > kept_row) begin
          drow = trow + AHEAD_ROWS;
          srow = drow % MAP_ROWS;
        end else begin
          drow = trow;
          srow = trow;
        end
        d    = tcol % RING_TILES;
        scol = tcol % MAP_COLS;
        if (d == 0) begin
          queue_copy(scol, srow, 0, drow, STRIP_COLS, 1);
        end else begin
          w = RING_TILES - d;
          queue_copy(scol, srow, d, drow, w, 1);
          queue_copy((tcol + w) % MAP_COLS, srow, d + w, drow, STRIP_COLS - w, 1);
        end
        kept_row = trow;
      end
    end

    if (planned_copies.size() > n0)
      planned_copies[planned_copies.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Input driver: holds a frame until taken, random idle bursts between frames
  always @(posedge clk) begin
    cam_frame_t f;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        plan_frame(in_tdata[15:0], in_tdata[31:16], in_tuser);
        frames_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap == 0 && $urandom_range(0, 99) < in_idle_pct)
          in_gap = $urandom_range(1, 5);
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          f = frames_to_send.pop_front();
          in_tdata  <= {f.cam_y, f.cam_x};
          in_tuser  <= f.refresh;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each transaction with the oldest planned copy
  always @(posedge clk) begin
    copy_t want;
    req_t  got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(req_t)-1:0];
        if (planned_copies.size() == 0) begin
          $error("unexpected copy request, tdata %h", out_tdata);
          err_count++;
        end else begin
          want = planned_copies.pop_front();
          check_field("src_col", 32'(want.req.src_col), 32'(got.src_col));
          check_field("src_row", 32'(want.req.src_row), 32'(got.src_row));
          check_field("dst_col", 32'(want.req.dst_col), 32'(got.dst_col));
          check_field("dst_row", 32'(want.req.dst_row), 32'(got.dst_row));
          check_field("width_tiles", 32'(want.req.width_tiles), 32'(got.width_tiles));
          check_field("row_count", 32'(want.req.row_count), 32'(got.row_count));
          check_field("last", 32'(want.last), 32'(out_tlast));
          copies_checked++;
        end
      end
      if (out_stall == 0 && $urandom_range(0, 99) < out_stall_pct)
        out_stall = $urandom_range(1, 5);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void add_frame(int x, int y, bit refresh);
    cam_frame_t f;
    f.cam_x   = 16'(x);
    f.cam_y   = 16'(y);
    f.refresh = refresh;
    frames_to_send.push_back(f);
  endfunction

  // Mostly small camera moves; some jumps and some fully random words
  function automatic void add_walk_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      add_frame(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                $urandom_range(0, 3) == 0);
    end else begin
      if (r < 22) begin
        walk_x = int'($urandom_range(0, int'(x_limit) + 16)) - 8;
        walk_y = int'($urandom_range(0, 600)) - 8;
      end else begin
        walk_x += int'($urandom_range(0, 20)) - 10;
        walk_y += int'($urandom_range(0, 20)) - 10;
      end
      if (walk_x > int'(x_limit) + 24) walk_x = int'(x_limit);
      if (walk_x < -24) walk_x = 0;
      if (walk_y > 700) walk_y = 640;
      if (walk_y < -24) walk_y = 0;
      add_frame(walk_x, walk_y, $urandom_range(0, 9) == 0);
    end
  endfunction

  // Wait until every frame is taken and every request seen, then let the pipe settle
  task automatic drain();
    while (frames_to_send.size() != 0 || in_tvalid || planned_copies.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_x_limit(logic [11:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    x_limit = v;
  endtask

  task automatic run_walk(int n, int unsigned idle, int unsigned stall);
    in_idle_pct   = idle;
    out_stall_pct = stall;
    repeat (n) add_walk_frame();
    drain();
  endtask

  initial begin
    x_limit  = MAX_X_RESET;
    kept_col = 0;
    kept_row = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset clamp of 240 pixels
    in_idle_pct   = 20;
    out_stall_pct = 20;
    add_frame(0, 0, 0);               // nothing moved: no request
    add_frame(0, 0, 1);               // refresh at ring origin, one piece
    add_frame(8, 0, 0);               // column step right
    add_frame(0, 0, 0);               // column step left
    add_frame(0, 8, 0);               // row step down at column 0
    add_frame(8, 16, 0);              // diagonal step, row strip in two pieces
    add_frame(8, 8, 0);               // row step up
    add_frame(-1, 8, 0);              // negative x clamps to 0
    add_frame(32767, 8, 0);           // x above clamp, column jump, full copy split
    add_frame(240, -32768, 0);        // negative y clamps to 0, row step up
    add_frame(240, 32767, 0);         // row jump to far end
    add_frame(232, 160, 1);           // refresh, column step, row jump
    add_frame(240, 168, 1);           // refresh, column step, row step: five requests
    add_frame(240, 168, 0);           // no change
    add_frame(16, 168, 0);            // column jump back
    add_frame(16, -1, 0);             // row jump to top
    add_frame(24, 312, 0);            // column strip near map bottom, then row jump
    add_frame(16'hFFFF, 16'h7FFF, 1); // refresh plus column jump
    add_frame(16'h8000, 16'h8000, 0); // row jump back to 0
    add_frame(16'h5555, 16'h2AAA, 0);
    add_frame(16'hAAAA, 16'h5555, 1);
    add_frame(16'h7FFF, 16'hFFFF, 0);
    drain();

    // Random walks under several clamp settings
    set_x_limit(12'd4095);
    run_walk(70, 30, 30);
    set_x_limit(12'd0);
    run_walk(40, 0, 0);
    set_x_limit(12'($urandom_range(1, 4094)));
    run_walk(70, 50, 50);
    set_x_limit(MAX_X_RESET);
    run_walk(60, 0, 0);

    if (planned_copies.size() != 0) begin
      $error("%0d copy requests never arrived", planned_copies.size());
      err_count++;
    end
    $display("Covered %0d camera frames under four x clamp settings (reset, 0, 4095, random).",
             frames_taken);
    $display("Checked %0d copy requests against the prediction, %0d errors.",
             copies_checked, err_count);
    if (err_count == 0)
      $display("PASS scroll_tile_refresh_planner");
    else
      $display("FAIL scroll_tile_refresh_planner");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL scroll_tile_refresh_planner");
    $finish;
  end

endmodule
